// ----- rtl/core/ptx_pkg.sv -----
// Shared types and constants for the point transform engine.
package ptx_pkg;

    // Default number of fraction bits in the signed fixed-point format.
    parameter int FRAC_BITS_DEF = 16;

    // Data word width and matrix shape.
    localparam int WORD_W    = 32;
    localparam int MAT_DIM   = 4;
    localparam int MAT_ELEMS = MAT_DIM * MAT_DIM;
    localparam int IDX_W     = $clog2(MAT_ELEMS);

    // Product width before the fraction shift.
    localparam int PROD_W = 2 * WORD_W;

    // Action codes carried by an input transaction.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_POINT = 1'b1;

    typedef logic signed [WORD_W-1:0] ptx_word_t;
    typedef logic [IDX_W-1:0]         ptx_idx_t;

    // Load enables for the column pipeline stages.
    typedef struct packed {
        logic ld_mul;
        logic ld_add;
        logic ld_sat;
    } ptx_stage_en_t;

endpackage

// ----- rtl/core/ptx_if.sv -----
// Stream interfaces for the point transform engine input and result channels.
interface ptx_in_if;
    import ptx_pkg::*;

    logic      valid;
    logic      ready;
    logic      action;
    ptx_idx_t  elem_index;
    ptx_word_t elem_value;
    ptx_word_t coord_x;
    ptx_word_t coord_y;
    ptx_word_t coord_z;
    logic      last_point;

    modport source (
        output valid, action, elem_index, elem_value, coord_x, coord_y, coord_z, last_point,
        input  ready
    );

    modport sink (
        input  valid, action, elem_index, elem_value, coord_x, coord_y, coord_z, last_point,
        output ready
    );
endinterface

interface ptx_out_if;
    import ptx_pkg::*;

    logic      valid;
    logic      ready;
    ptx_word_t out_x;
    ptx_word_t out_y;
    ptx_word_t out_z;
    ptx_word_t out_w;
    logic      out_last;

    modport source (
        output valid, out_x, out_y, out_z, out_w, out_last,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_w, out_last,
        output ready
    );
endinterface

// ----- rtl/core/point_transform_4x4.sv -----
// A point transaction is registered through the input, multiply, pairwise add and final add
// stages, and its result is then offered on the result channel until the result side is ready.
// One transaction per cycle while the result side does not stall, set by the four-stage
// column pipeline (input register, multiply, pairwise add, final add with saturation).
// Load transactions take one slot, write the matrix from the input stage and give no result.
// Reset (rst_n, asynchronous): pipeline emptied, matrix set to the identity, 3D mode off.
module point_transform_4x4
    import ptx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    ptx_in_if.sink    point_in,
    ptx_out_if.source result_out,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    // Valid bits of the four stages.
    logic          v1_reg;
    logic          v2_reg;
    logic          v3_reg;
    logic          v4_reg;
    logic          v2_next;

    // Per-stage readiness; a stage takes new data when it is empty or moving on.
    logic          rdy1;
    logic          rdy2;
    logic          rdy3;
    logic          rdy4;

    // Input stage payload.
    logic          act1_reg;
    ptx_idx_t      idx1_reg;
    ptx_word_t     val1_reg;
    ptx_word_t     x1_reg;
    ptx_word_t     y1_reg;
    ptx_word_t     z1_reg;
    logic          last1_reg;
    logic          last2_reg;
    logic          last3_reg;
    logic          last4_reg;

    logic          three_d_only_reg;
    logic          mat_wr_en;
    ptx_stage_en_t col_en;
    ptx_word_t     elem [MAT_ELEMS];
    ptx_word_t     col_res [MAT_DIM];

    // Ready chain from the output back to the input.
    assign rdy4 = !v4_reg || result_out.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign point_in.ready = rdy1;

    // Only point transactions travel beyond the input stage.
    assign v2_next = v1_reg && (act1_reg == ACT_POINT);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_d_only_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            three_d_only_reg <= cfg_wdata;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= point_in.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v2_next;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Input stage payload capture.
    always_ff @(posedge clk)
    begin
        if (rdy1 && point_in.valid)
        begin
            act1_reg  <= point_in.action;
            idx1_reg  <= point_in.elem_index;
            val1_reg  <= point_in.elem_value;
            x1_reg    <= point_in.coord_x;
            y1_reg    <= point_in.coord_y;
            z1_reg    <= point_in.coord_z;
            last1_reg <= point_in.last_point;
        end
    end

    // Last flag follows the column pipeline.
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            last2_reg <= last1_reg;
        end
        if (rdy3)
        begin
            last3_reg <= last2_reg;
        end
        if (rdy4)
        begin
            last4_reg <= last3_reg;
        end
    end

    // A load writes the matrix as it leaves the input stage, so points keep their order.
    assign mat_wr_en = v1_reg && (act1_reg == ACT_LOAD) && rdy2;

    ptx_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mat_wr_en),
        .wr_index (idx1_reg),
        .wr_value (val1_reg),
        .elem     (elem)
    );

    assign col_en.ld_mul = rdy2;
    assign col_en.ld_add = rdy3;
    assign col_en.ld_sat = rdy4;

    // One column datapath per output; the w column is cleared in 3D mode.
    for (genvar c = 0; c < MAT_DIM; c++)
    begin : g_col
        ptx_column #(
            .FRAC_BITS (FRAC_BITS)
        ) u_column (
            .clk        (clk),
            .en         (col_en),
            .x          (x1_reg),
            .y          (y1_reg),
            .z          (z1_reg),
            .m_x        (elem[c]),
            .m_y        (elem[MAT_DIM + c]),
            .m_z        (elem[2 * MAT_DIM + c]),
            .m_bias     (elem[3 * MAT_DIM + c]),
            .force_zero ((c == MAT_DIM - 1) && three_d_only_reg),
            .result     (col_res[c])
        );
    end

    // Result channel.
    assign result_out.valid    = v4_reg;
    assign result_out.out_x    = col_res[0];
    assign result_out.out_y    = col_res[1];
    assign result_out.out_z    = col_res[2];
    assign result_out.out_w    = col_res[3];
    assign result_out.out_last = last4_reg;

endmodule

// ----- rtl/core/ptx_matrix.sv -----
// Transform matrix register file, reset to the identity and written one element at a time.
module ptx_matrix
    import ptx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  ptx_idx_t  wr_index,
    input  ptx_word_t wr_value,
    output ptx_word_t elem [MAT_ELEMS]
);

    // Fixed-point one, placed on the diagonal at reset.
    localparam ptx_word_t ONE = ptx_word_t'(64'sd1 <<< FRAC_BITS);

    ptx_word_t mat_reg [MAT_ELEMS];

    // Element storage with identity reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_ELEMS; i++)
            begin
                mat_reg[i] <= ((i / MAT_DIM) == (i % MAT_DIM)) ? ONE : '0;
            end
        end
        else if (wr_en)
        begin
            mat_reg[wr_index] <= wr_value;
        end
    end

    assign elem = mat_reg;

endmodule

// ----- rtl/core/ptx_column.sv -----
// One output column: three products, a two-level sum with the bias row and saturation.
module ptx_column
    import ptx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  ptx_stage_en_t en,
    input  ptx_word_t     x,
    input  ptx_word_t     y,
    input  ptx_word_t     z,
    input  ptx_word_t     m_x,
    input  ptx_word_t     m_y,
    input  ptx_word_t     m_z,
    input  ptx_word_t     m_bias,
    input  logic          force_zero,
    output ptx_word_t     result
);

    // Width of a product after the floor shift, and of the growing sums.
    localparam int SH_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W = SH_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'($signed(32'h8000_0000));

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;

    logic signed [SH_W-1:0]   px_reg;
    logic signed [SH_W-1:0]   py_reg;
    logic signed [SH_W-1:0]   pz_reg;
    ptx_word_t                bias_reg;

    logic signed [SUM_W-1:0]  sum_a_reg;
    logic signed [SUM_W-1:0]  sum_b_reg;
    logic signed [SUM_W-1:0]  total;
    ptx_word_t                sat_value;
    ptx_word_t                result_reg;

    // Full-precision signed products.
    assign prod_x = PROD_W'(x) * PROD_W'(m_x);
    assign prod_y = PROD_W'(y) * PROD_W'(m_y);
    assign prod_z = PROD_W'(z) * PROD_W'(m_z);

    // Multiply stage: dropping the low fraction bits of a signed value floors it.
    always_ff @(posedge clk)
    begin
        if (en.ld_mul)
        begin
            px_reg   <= prod_x[PROD_W-1:FRAC_BITS];
            py_reg   <= prod_y[PROD_W-1:FRAC_BITS];
            pz_reg   <= prod_z[PROD_W-1:FRAC_BITS];
            bias_reg <= m_bias;
        end
    end

    // First adder level: two pairwise sums.
    always_ff @(posedge clk)
    begin
        if (en.ld_add)
        begin
            sum_a_reg <= SUM_W'(px_reg) + SUM_W'(py_reg);
            sum_b_reg <= SUM_W'(pz_reg) + SUM_W'(bias_reg);
        end
    end

    // Final sum and clamp to the signed word range.
    assign total = sum_a_reg + sum_b_reg;

    always_comb
    begin
        if (total > SAT_HI)
        begin
            sat_value = SAT_HI[WORD_W-1:0];
        end
        else if (total < SAT_LO)
        begin
            sat_value = SAT_LO[WORD_W-1:0];
        end
        else
        begin
            sat_value = total[WORD_W-1:0];
        end
    end

    // Output register of the column.
    always_ff @(posedge clk)
    begin
        if (en.ld_sat)
        begin
            result_reg <= force_zero ? '0 : sat_value;
        end
    end

    assign result = result_reg;

endmodule
